FILE: design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared constants and types for the bounded deque
// Sizes of the ring store, the count and the capacity register, and the
// request operation codes.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CAP_W   = 11;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [CMP_W-1:0]   cmp_t;

  localparam op_t OP_PUSH_FRONT = op_t'(0);
  localparam op_t OP_PUSH_REAR  = op_t'(1);
  localparam op_t OP_POP_FRONT  = op_t'(2);
  localparam op_t OP_POP_REAR   = op_t'(3);
  localparam op_t OP_QUERY      = op_t'(4);

endpackage

FILE: design/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue with a configurable capacity
// Ring store in one synchronous RAM (one write port, two read ports),
// addressed by a head pointer and an entry count.
// ----------------------------------------------------------------------------
// channel | ports                          | direction
// in      | in_valid/in_ready, operation,  | request beat into the block
//         | value                          |
// out     | out_valid/out_ready, success,  | one result beat per request
//         | ends, flags, entry_count       |
// cfg     | cfg_we, cfg_wdata              | capacity write, no wait
//
// A request passes in order through accept (pointer update and RAM write),
// RAM read of both ends, and load into the output register.
// A new request is taken while the previous result waits in the output
// register; the load step holds until that result beat is taken.
// Reset (rst_n low, synchronous) clears head and count and sets capacity to
// 1024; the RAM is not cleared, only written slots are ever reported.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdq_pkg::OP_W-1:0]     in_operation,
  input  logic [bdq_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_success,
  output logic [bdq_pkg::VALUE_W-1:0]  out_front_value,
  output logic [bdq_pkg::VALUE_W-1:0]  out_rear_value,
  output logic                         out_ends_valid,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  output logic [bdq_pkg::CNT_W-1:0]    out_entry_count
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD} state_t;

  localparam int unsigned SUM_W = bdq_pkg::CNT_W + 1;

  state_t             state_r;
  bdq_pkg::addr_t     head_r, head_nxt;
  bdq_pkg::count_t    count_r, count_nxt;
  bdq_pkg::cap_t      cap_r;
  logic               ok_r, ok_nxt;
  logic               wr_en;
  bdq_pkg::addr_t     wr_addr;
  bdq_pkg::addr_t     head_inc, head_dec, tail_addr, rear_addr;
  bdq_pkg::count_t    count_m1;
  bdq_pkg::cmp_t      cap_ext, cap_eff;
  logic               full;
  logic               accept;
  logic               load;

  bdq_pkg::value_t    mem [bdq_pkg::DEPTH];
  bdq_pkg::value_t    rd_front_r, rd_rear_r;

  logic               out_valid_r;
  logic               out_success_r;
  bdq_pkg::value_t    out_front_r, out_rear_r;
  logic               out_ends_r, out_empty_r, out_full_r;
  bdq_pkg::count_t    out_count_r;

  function automatic bdq_pkg::addr_t ring_wrap(logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    d = SUM_W'(bdq_pkg::DEPTH);
    if (s >= d) begin
      return bdq_pkg::ADDR_W'(s - d);
    end
    return bdq_pkg::ADDR_W'(s);
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign load     = (state_r == S_LOAD) && (!out_valid_r || out_ready);

  assign cap_ext = bdq_pkg::CMP_W'(cap_r);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = bdq_pkg::CMP_W'(1);
    end else if (cap_ext > bdq_pkg::CMP_W'(bdq_pkg::DEPTH)) begin
      cap_eff = bdq_pkg::CMP_W'(bdq_pkg::DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign full = bdq_pkg::CMP_W'(count_r) >= cap_eff;

  assign head_inc  = (head_r == bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1)) ? '0
                                                                     : head_r + 1'b1;
  assign head_dec  = (head_r == '0) ? bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1)
                                    : head_r - 1'b1;
  assign tail_addr = ring_wrap(SUM_W'(head_r) + SUM_W'(count_r));
  assign count_m1  = (count_r == '0) ? '0 : count_r - 1'b1;
  assign rear_addr = ring_wrap(SUM_W'(head_r) + SUM_W'(count_m1));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_addr;
    case (in_operation)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          head_nxt  = head_dec;
          wr_addr   = head_dec;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::OP_PUSH_REAR: begin
        if (!full) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (count_r != '0) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::OP_POP_REAR: begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::OP_QUERY: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // ring store
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_front_r <= mem[head_r];
      rd_rear_r  <= mem[rear_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bdq_pkg::CAP_W'(1024);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            head_r  <= head_nxt;
            count_r <= count_nxt;
            ok_r    <= ok_nxt;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            out_success_r <= ok_r;
            out_front_r   <= (count_r != '0) ? rd_front_r : '0;
            out_rear_r    <= (count_r != '0) ? rd_rear_r : '0;
            out_ends_r    <= (count_r != '0);
            out_empty_r   <= (count_r == '0);
            out_full_r    <= full;
            out_count_r   <= count_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_ends_valid  = out_ends_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;
  assign out_entry_count = out_count_r;

endmodule

FILE: design/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker: port-level assertions for the bounded deque
// Watches the top level's ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module bdq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_we,
  input logic [bdq_pkg::CAP_W-1:0]    cfg_wdata,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bdq_pkg::OP_W-1:0]     in_operation,
  input logic [bdq_pkg::VALUE_W-1:0]  in_value,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_success,
  input logic [bdq_pkg::VALUE_W-1:0]  out_front_value,
  input logic [bdq_pkg::VALUE_W-1:0]  out_rear_value,
  input logic                         out_ends_valid,
  input logic                         out_is_empty,
  input logic                         out_is_full,
  input logic [bdq_pkg::CNT_W-1:0]    out_entry_count
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_front_value)
      && $stable(out_rear_value) && $stable(out_entry_count)
      && $stable(out_success))
    else $error("result beat changed while stalled");

  a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty != out_ends_valid)
      && (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag, ends flag and count disagree");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == '0 && out_rear_value == '0)
    else $error("empty deque reports nonzero ends");

  a_one_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == 1 |-> out_front_value == out_rear_value)
    else $error("single entry with different ends");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (.*);

FILE: dv/bounded_deque_checker.sv
// ----------------------------------------------------------------------------
// bounded_deque_checker: result checker for the bounded deque
// Watches the request, result and capacity ports, keeps its own copy of the
// ring store, head, count and capacity, and works out the deque view that
// each accepted request beat must produce. Result beats are compared field by
// field, in order, against the oldest outstanding view.
// ----------------------------------------------------------------------------
module bounded_deque_checker import bdq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_success,
  input  logic [VALUE_W-1:0] out_front_value,
  input  logic [VALUE_W-1:0] out_rear_value,
  input  logic               out_ends_valid,
  input  logic               out_is_empty,
  input  logic               out_is_full,
  input  logic [CNT_W-1:0]   out_entry_count,
  output int                 mismatch_count,
  output int                 views_pending
);

  typedef struct packed {
    logic   success;
    value_t front;
    value_t rear;
    logic   ends_valid;
    logic   is_empty;
    logic   is_full;
    count_t count;
  } deque_view_t;

  value_t      ring [DEPTH];
  addr_t       head;
  int          held;
  cap_t        capacity;
  deque_view_t expected_views [$];
  int          beat_no;

  function automatic int usable_capacity();
    if (capacity == 0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return capacity;
  endfunction

  function automatic deque_view_t apply_request(input op_t op, input value_t v);
    deque_view_t view;
    int          room;
    logic        ok;
    room = usable_capacity();
    ok = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (held < room) begin
          head = head - 1'b1;
          ring[head] = v;
          held++;
          ok = 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (held < room) begin
          ring[addr_t'(head + held)] = v;
          held++;
          ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held != 0) begin
          head = head + 1'b1;
          held--;
          ok = 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (held != 0) begin
          held--;
          ok = 1'b1;
        end
      end
      OP_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    view.success    = ok;
    view.ends_valid = (held != 0);
    view.is_empty   = (held == 0);
    view.is_full    = (held >= room);
    view.count      = count_t'(held);
    view.front      = (held != 0) ? ring[head] : '0;
    view.rear       = (held != 0) ? ring[addr_t'(head + held - 1)] : '0;
    return view;
  endfunction

  task automatic report(input string what);
    if (mismatch_count < 100) $display("bounded_deque_checker: beat %0d: %s", beat_no, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (!rst_n) begin
      head = '0;
      held = 0;
      capacity = cap_t'(DEPTH);
      expected_views.delete();
      beat_no = 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          report("result beat with no request outstanding");
        end else begin
          want = expected_views.pop_front();
          compare_field("success", out_success, want.success);
          compare_field("front_value", out_front_value, want.front);
          compare_field("rear_value", out_rear_value, want.rear);
          compare_field("ends_valid", out_ends_valid, want.ends_valid);
          compare_field("is_empty", out_is_empty, want.is_empty);
          compare_field("is_full", out_is_full, want.is_full);
          compare_field("entry_count", out_entry_count, want.count);
        end
        beat_no++;
      end
      if (in_valid && in_ready) expected_views.push_back(apply_request(in_operation, in_value));
    end
    views_pending = expected_views.size();
  end

endmodule

FILE: dv/bounded_deque_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_tb: testbench top for the bounded deque
// Resets the block, sends a directed set of requests on an empty, one-entry
// and two-end deque, then random request streams under a series of
// capacities (zero, one, small, lowered below the count, and the full ring).
// The sender works in bursts with gaps, the receiver stalls in changing
// patterns, and a checker beside the block predicts every result beat.
// ----------------------------------------------------------------------------
module bounded_deque_tb import bdq_pkg::*; ();

  localparam op_t OP_BAD_FIRST = op_t'(OP_QUERY + 1);
  localparam op_t OP_BAD_LAST  = '1;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CAP_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_success;
  logic [VALUE_W-1:0] out_front_value;
  logic [VALUE_W-1:0] out_rear_value;
  logic               out_ends_valid;
  logic               out_is_empty;
  logic               out_is_full;
  logic [CNT_W-1:0]   out_entry_count;
  int                 mismatches;
  int                 results_owed;
  int                 burst_left;
  rx_mode_e           rx_mode = RX_OPEN;
  int                 rx_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_deque dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_success     (out_success),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_ends_valid  (out_ends_valid),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count)
  );

  bounded_deque_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_success     (out_success),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_ends_valid  (out_ends_valid),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_entry_count (out_entry_count),
    .mismatch_count  (mismatches),
    .views_pending   (results_owed)
  );

  // receiver: stall pattern is chosen at random, anew after each random-length run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_PULSE));
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= (rx_left % 8 == 0);
    endcase
  end

  // one request beat; called and returns at a falling edge
  task automatic dispatch(input op_t op, input value_t v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if ($urandom_range(0, 15) == 0) begin
        while (results_owed != 0) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(input int cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap_t'(cap);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int cap, input int items, input int push_pct,
                           input int pop_pct);
    op_t    op;
    value_t v;
    int     pick;
    set_capacity(cap);
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else if (pick < push_pct + pop_pct) begin
        op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
      end else if (pick % 2 == 0) begin
        op = OP_QUERY;
      end else begin
        op = op_t'(OP_BAD_FIRST + $urandom_range(0, OP_BAD_LAST - OP_BAD_FIRST));
      end
      if ($urandom_range(0, 7) == 0) begin
        v = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        v = value_t'($urandom_range(0, 16'hFFFF));
      end
      dispatch(op, v);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_operation = OP_QUERY;
    in_value     = '0;
    burst_left   = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty deque, unknown codes, both ends at reset capacity
    dispatch(OP_QUERY, 16'h0000);
    dispatch(OP_POP_FRONT, 16'hFFFF);
    dispatch(OP_POP_REAR, 16'hFFFF);
    dispatch(OP_BAD_FIRST, 16'hFFFF);
    dispatch(op_t'(OP_BAD_FIRST + 1), 16'h0000);
    dispatch(OP_BAD_LAST, 16'hFFFF);
    dispatch(OP_PUSH_FRONT, 16'hFFFF);
    dispatch(OP_PUSH_REAR, 16'h0000);
    dispatch(OP_PUSH_FRONT, 16'hAAAA);
    dispatch(OP_PUSH_REAR, 16'h5555);
    dispatch(OP_QUERY, 16'h1234);
    dispatch(OP_BAD_LAST, 16'h4321);
    dispatch(OP_POP_FRONT, 16'h0000);
    dispatch(OP_POP_REAR, 16'h0000);
    dispatch(OP_POP_FRONT, 16'h0000);
    dispatch(OP_POP_REAR, 16'h0000);
    dispatch(OP_POP_REAR, 16'h0000);
    // capacity zero acts as one
    set_capacity(0);
    dispatch(OP_PUSH_REAR, 16'h1234);
    dispatch(OP_PUSH_FRONT, 16'hFFFF);
    dispatch(OP_PUSH_REAR, 16'h0001);
    dispatch(OP_POP_FRONT, 16'h0000);
    dispatch(OP_POP_FRONT, 16'h0000);

    run_phase(1, 80, 45, 35);
    run_phase(16, 150, 60, 25);
    run_phase(4, 150, 35, 55);
    run_phase(0, 60, 45, 40);
    run_phase(2047, 1150, 95, 3);
    run_phase(1024, 150, 20, 70);
    run_phase(600, 100, 40, 40);

    settle();
    if (mismatches == 0) begin
      $display("bounded_deque_tb: PASS");
    end else begin
      $display("bounded_deque_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("bounded_deque_tb: FAIL");
    $finish;
  end

endmodule
